// ----- src/pwsm_pkg.sv -----
// -----------------------------------------------------------------------------
// pwsm_pkg
// Shared widths, register indexes and controller states of the speed meter.
// -----------------------------------------------------------------------------
package pwsm_pkg;

   localparam int TICK_W     = 32;
   localparam int PULSE_W    = 32;
   localparam int RPM_W      = 24;
   localparam int SPEED_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int SAMPLE_W   = 8;
   localparam int WINDOW_W   = 16;
   localparam int HOLES_W    = 8;
   localparam int TPM_W      = 16;
   localparam int FACTOR_W   = 16;

   // Product and divisor widths of the long-hand datapath
   localparam int NUM_W      = PULSE_W + TPM_W;      // pulses * ticks_per_minute
   localparam int DIV_W      = TICK_W + HOLES_W;     // ticks * holes_per_rev
   localparam int PROD_W     = NUM_W + FACTOR_W;     // numerator * speed factor

   localparam int MUL_STEPS  = 16;                   // one multiplier bit a cycle
   localparam int DIV_STEPS  = NUM_W;                // one quotient bit a cycle
   localparam int CNT_W      = 6;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_SAMPLE_TICKS     = 3'd0;
   localparam csr_idx_type CSR_WINDOW_TICKS     = 3'd1;
   localparam csr_idx_type CSR_HOLES_PER_REV    = 3'd2;
   localparam csr_idx_type CSR_TICKS_PER_MINUTE = 3'd3;
   localparam csr_idx_type CSR_SPEED_FACTOR     = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_ACCUM,
      ST_CHECK,
      ST_MUL_RATE,
      ST_MUL_SPEED,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

// ----- src/pulse_window_speed_meter.sv -----
// -----------------------------------------------------------------------------
// pulse_window_speed_meter
// Wheel speed from a wrapping tick count and a wrapping encoder pulse total.
// -----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one timestamp and pulse total per timer tick.
//   Response channel (rsp_*): rpm, km/h value and a clip flag, produced only
//   when the accumulated ticks reach window_ticks.
//   Configuration (csr_*): write-only registers, written while idle.
// Request flow:
//   The first request after reset only primes the stored values; the next
//   request can be accepted in the following cycle. A request that yields no
//   response keeps req_stall high through the SAMPLE, ACCUM and CHECK states.
//   A request that closes a window then runs two shift-add multipliers and a
//   restoring divider (one quotient bit per cycle for rpm and speed in
//   parallel) before rsp_valid rises; a zero divisor skips straight to EMIT.
// Stall and reset:
//   The response sits in an output register; while the receiver stalls it
//   holds, and the block still accepts and accumulates new requests, waiting
//   only if a second response is ready before the first is taken.
//   Synchronous reset restores register defaults and clears the accumulators.
// -----------------------------------------------------------------------------
module pulse_window_speed_meter
   import pwsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TICK_W-1:0]     req_now_ticks,
   input  logic [PULSE_W-1:0]    req_pulse_total,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [RPM_W-1:0]      rsp_rpm_value,
   output logic [SPEED_W-1:0]    rsp_kmh_value,
   output logic                  rsp_saturated,

   input  logic                  csr_wr_en,
   input  csr_idx_type           csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [SAMPLE_W-1:0] sample_ticks_ff;
   logic [WINDOW_W-1:0] window_ticks_ff;
   logic [HOLES_W-1:0]  holes_ff;
   logic [TPM_W-1:0]    tpm_ff;
   logic [FACTOR_W-1:0] factor_ff;

   // Controller
   state_type state_ff, state_in;
   logic      req_take;
   logic      out_free;
   logic      mul_last;
   logic      div_last;
   logic      sample_ok;
   logic      window_due;
   logic      zero_div;

   // Sampling state
   logic                primed_ff;
   logic [TICK_W-1:0]   prev_ticks_ff;
   logic [PULSE_W-1:0]  prev_pulses_ff;
   logic [TICK_W-1:0]   now_ff;
   logic [PULSE_W-1:0]  pulse_ff;
   logic [TICK_W-1:0]   elapsed_ff;
   logic [PULSE_W-1:0]  dpulse_ff;
   logic [PULSE_W-1:0]  acc_pulse_ff;
   logic [TICK_W-1:0]   acc_tick_ff;

   // Arithmetic datapath
   logic [CNT_W-1:0]    cnt_ff;
   logic [FACTOR_W-1:0] mult_sr_ff;
   logic [FACTOR_W-1:0] holes_sr_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [DIV_W-1:0]    div_ff;
   logic [PROD_W-1:0]   x_ff;
   logic [DIV_W-1:0]    rem_a_ff;
   logic [DIV_W-1:0]    rem_b_ff;
   logic [RPM_W-1:0]    q_rpm_ff;
   logic [SPEED_W-1:0]  q_spd_ff;
   logic                ovf_rpm_ff;
   logic                ovf_spd_ff;
   logic                zero_div_ff;

   logic [DIV_W:0]      trial_a;
   logic [DIV_W:0]      trial_b;
   logic [DIV_W+1:0]    diff_a;
   logic [DIV_W+1:0]    diff_b;
   logic                ge_a;
   logic                ge_b;

   // Response register
   logic                rsp_valid_ff;
   logic [RPM_W-1:0]    rsp_rpm_ff;
   logic [SPEED_W-1:0]  rsp_speed_ff;
   logic                rsp_sat_ff;

   // ---------------------------------------------------------------------------
   // Configuration writes; unknown indexes are dropped
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ticks_ff <= SAMPLE_W'(2);
         window_ticks_ff <= WINDOW_W'(20);
         holes_ff        <= HOLES_W'(20);
         tpm_ff          <= TPM_W'(6000);
         factor_ff       <= FACTOR_W'(823);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SAMPLE_TICKS:     sample_ticks_ff <= csr_wdata[SAMPLE_W-1:0];
            CSR_WINDOW_TICKS:     window_ticks_ff <= csr_wdata[WINDOW_W-1:0];
            CSR_HOLES_PER_REV:    holes_ff        <= csr_wdata[HOLES_W-1:0];
            CSR_TICKS_PER_MINUTE: tpm_ff          <= csr_wdata[TPM_W-1:0];
            CSR_SPEED_FACTOR:     factor_ff       <= csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Controller
   // ---------------------------------------------------------------------------
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign mul_last   = (cnt_ff == CNT_W'(MUL_STEPS - 1));
   assign div_last   = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign sample_ok  = (elapsed_ff >= TICK_W'(sample_ticks_ff));
   assign window_due = (acc_tick_ff >= TICK_W'(window_ticks_ff));
   assign zero_div   = (acc_tick_ff == '0) || (holes_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            // priming request stays here; later ones go sample
            if (req_valid && primed_ff) begin
               state_in = ST_SAMPLE;
            end
         end
         ST_SAMPLE: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (!window_due) begin
               state_in = ST_IDLE;
            end else if (zero_div) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL_RATE;
            end
         end
         ST_MUL_RATE: begin
            if (mul_last) begin
               state_in = ST_MUL_SPEED;
            end
         end
         ST_MUL_SPEED: begin
            if (mul_last) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold the finished result until the output register frees up
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Sampling and window accumulation
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         acc_pulse_ff <= '0;
         acc_tick_ff  <= '0;
      end else begin
         if (req_take && !primed_ff) begin
            primed_ff <= 1'b1;
         end
         if (state_ff == ST_ACCUM && sample_ok) begin
            acc_pulse_ff <= acc_pulse_ff + dpulse_ff;
            acc_tick_ff  <= acc_tick_ff + elapsed_ff;
         end
         // window closed: drop the sums once the result is handed over
         if (state_ff == ST_EMIT && out_free) begin
            acc_pulse_ff <= '0;
            acc_tick_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff   <= req_now_ticks;
         pulse_ff <= req_pulse_total;
         if (!primed_ff) begin
            prev_ticks_ff  <= req_now_ticks;
            prev_pulses_ff <= req_pulse_total;
         end
      end
      if (state_ff == ST_SAMPLE) begin
         // wrapped deltas, modulo 2^32
         elapsed_ff <= now_ff - prev_ticks_ff;
         dpulse_ff  <= pulse_ff - prev_pulses_ff;
      end
      if (state_ff == ST_ACCUM && sample_ok) begin
         prev_ticks_ff  <= now_ff;
         prev_pulses_ff <= pulse_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Bit-serial arithmetic
   //   MUL_RATE : num = P * T and div = K * H, MSB-first shift-add
   //   MUL_SPEED: x = num * S, MSB-first shift-add
   //   DIVIDE   : restoring division of num and x[63:16] by div, one
   //              quotient bit per cycle; bits leaving the result windows
   //              mark saturation
   // ---------------------------------------------------------------------------
   assign trial_a = {rem_a_ff, num_ff[NUM_W-1]};
   assign trial_b = {rem_b_ff, x_ff[PROD_W-1]};
   assign diff_a  = {1'b0, trial_a} - {2'b00, div_ff};
   assign diff_b  = {1'b0, trial_b} - {2'b00, div_ff};
   assign ge_a    = !diff_a[DIV_W+1];
   assign ge_b    = !diff_b[DIV_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         case (state_ff)
            ST_MUL_RATE, ST_MUL_SPEED: cnt_ff <= mul_last ? '0 : cnt_ff + CNT_W'(1);
            ST_DIVIDE:                 cnt_ff <= div_last ? '0 : cnt_ff + CNT_W'(1);
            default:                   cnt_ff <= '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_CHECK: begin
            mult_sr_ff  <= tpm_ff;
            holes_sr_ff <= FACTOR_W'(holes_ff);
            num_ff      <= '0;
            div_ff      <= '0;
            zero_div_ff <= zero_div;
         end
         ST_MUL_RATE: begin
            num_ff <= {num_ff[NUM_W-2:0], 1'b0}
                    + (mult_sr_ff[FACTOR_W-1] ? NUM_W'(acc_pulse_ff) : '0);
            div_ff <= {div_ff[DIV_W-2:0], 1'b0}
                    + (holes_sr_ff[FACTOR_W-1] ? DIV_W'(acc_tick_ff) : '0);
            holes_sr_ff <= {holes_sr_ff[FACTOR_W-2:0], 1'b0};
            if (mul_last) begin
               mult_sr_ff <= factor_ff;
               x_ff       <= '0;
            end else begin
               mult_sr_ff <= {mult_sr_ff[FACTOR_W-2:0], 1'b0};
            end
         end
         ST_MUL_SPEED: begin
            x_ff <= {x_ff[PROD_W-2:0], 1'b0}
                  + (mult_sr_ff[FACTOR_W-1] ? PROD_W'(num_ff) : '0);
            mult_sr_ff <= {mult_sr_ff[FACTOR_W-2:0], 1'b0};
            if (mul_last) begin
               rem_a_ff   <= '0;
               rem_b_ff   <= '0;
               q_rpm_ff   <= '0;
               q_spd_ff   <= '0;
               ovf_rpm_ff <= 1'b0;
               ovf_spd_ff <= 1'b0;
            end
         end
         ST_DIVIDE: begin
            rem_a_ff   <= ge_a ? diff_a[DIV_W-1:0] : trial_a[DIV_W-1:0];
            rem_b_ff   <= ge_b ? diff_b[DIV_W-1:0] : trial_b[DIV_W-1:0];
            num_ff     <= {num_ff[NUM_W-2:0], 1'b0};
            x_ff       <= {x_ff[PROD_W-2:0], 1'b0};
            q_rpm_ff   <= {q_rpm_ff[RPM_W-2:0], ge_a};
            q_spd_ff   <= {q_spd_ff[SPEED_W-2:0], ge_b};
            ovf_rpm_ff <= ovf_rpm_ff | q_rpm_ff[RPM_W-1];
            ovf_spd_ff <= ovf_spd_ff | q_spd_ff[SPEED_W-1];
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && out_free) begin
         if (zero_div_ff) begin
            rsp_rpm_ff   <= '0;
            rsp_speed_ff <= '0;
            rsp_sat_ff   <= 1'b0;
         end else begin
            rsp_rpm_ff   <= ovf_rpm_ff ? '1 : q_rpm_ff;
            rsp_speed_ff <= ovf_spd_ff ? '1 : q_spd_ff;
            rsp_sat_ff   <= ovf_rpm_ff | ovf_spd_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rpm_value  = rsp_rpm_ff;
   assign rsp_kmh_value  = rsp_speed_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

// ----- src/pwsm_check.sv -----
// -----------------------------------------------------------------------------
// pwsm_check
// Port-level checks for the speed meter, bound to the top level.
// -----------------------------------------------------------------------------
module pwsm_check
   import pwsm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [RPM_W-1:0]      rsp_rpm_value,
   input logic [SPEED_W-1:0]    rsp_kmh_value,
   input logic                  rsp_saturated
);

   // A stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_rpm_value) && $stable(rsp_kmh_value)
                                 && $stable(rsp_saturated))
      else $error("response payload changed while stalled");

   // The clip flag only comes with a clipped value
   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_rpm_value == '1) || (rsp_kmh_value == '1))
      else $error("saturated set without a clipped value");

   // No response can appear in the cycle right after a request
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("response raised one cycle after a request");

endmodule

bind pulse_window_speed_meter pwsm_check u_pwsm_check (.*);

// ----- verif/pulse_window_speed_meter_tb.sv -----
// -----------------------------------------------------------------------------
// pulse_window_speed_meter_tb
// Self-checking bench for the encoder speed meter. A scoreboard object mirrors
// the sampling, accumulation and rpm/speed arithmetic of the block, predicts a
// response for every window that closes, and compares each response the block
// hands over. Directed requests cover wrap-around, saturation and the
// zero-divisor corner; random phases then sweep the register settings with
// mostly steady tick/pulse streams, plus backward steps and random jumps.
// -----------------------------------------------------------------------------
module pulse_window_speed_meter_tb
   import pwsm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RESET_CYCLES   = 12;
   localparam int          SETTLE_CYCLES  = 100;   // covers the full result path
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          PHASE_ITEMS    = 130;
   localparam bit [63:0]   RPM_LIMIT      = (64'd1 << RPM_W) - 1;
   localparam bit [63:0]   SPEED_LIMIT    = (64'd1 << SPEED_W) - 1;

   typedef struct packed {
      logic [RPM_W-1:0]   rpm;
      logic [SPEED_W-1:0] speed;
      logic               sat;
   } speed_result_type;

   // Mirror of the block: registers, sampling state and the queue of speed
   // results still owed by the block.
   class speed_scoreboard;
      bit [SAMPLE_W-1:0] sample_ticks;
      bit [WINDOW_W-1:0] window_ticks;
      bit [HOLES_W-1:0]  holes_per_rev;
      bit [TPM_W-1:0]    ticks_per_minute;
      bit [FACTOR_W-1:0] speed_factor;
      bit                primed;
      bit [TICK_W-1:0]   prev_ticks;
      bit [PULSE_W-1:0]  prev_pulses;
      bit [PULSE_W-1:0]  pulse_sum;
      bit [TICK_W-1:0]   tick_sum;
      speed_result_type  owed_speeds[$];
      int                errors;

      function new();
         sample_ticks     = 8'd2;
         window_ticks     = 16'd20;
         holes_per_rev    = 8'd20;
         ticks_per_minute = 16'd6000;
         speed_factor     = 16'd823;
         primed           = 1'b0;
         prev_ticks       = '0;
         prev_pulses      = '0;
         pulse_sum        = '0;
         tick_sum         = '0;
         errors           = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SAMPLE_TICKS:     sample_ticks     = data[SAMPLE_W-1:0];
            CSR_WINDOW_TICKS:     window_ticks     = data[WINDOW_W-1:0];
            CSR_HOLES_PER_REV:    holes_per_rev    = data[HOLES_W-1:0];
            CSR_TICKS_PER_MINUTE: ticks_per_minute = data[TPM_W-1:0];
            CSR_SPEED_FACTOR:     speed_factor     = data[FACTOR_W-1:0];
            default: ;
         endcase
      endfunction

      // Exact floors of P*T/(K*H) and P*T*S/(K*H*2^16), then clip.
      function speed_result_type window_speed();
         bit [63:0]        divisor;
         bit [63:0]        product;
         bit [63:0]        quo;
         bit [63:0]        rem;
         bit [63:0]        scaled;
         bit [63:0]        kmh;
         speed_result_type res;
         res     = '0;
         divisor = 64'(tick_sum) * 64'(holes_per_rev);
         if (divisor == 0) begin
            return res;
         end
         product = 64'(pulse_sum) * 64'(ticks_per_minute);
         quo     = product / divisor;
         rem     = product % divisor;
         scaled  = quo * 64'(speed_factor) + (rem * 64'(speed_factor)) / divisor;
         kmh     = scaled >> 16;
         if (quo > RPM_LIMIT) begin
            res.rpm = '1;
            res.sat = 1'b1;
         end else begin
            res.rpm = quo[RPM_W-1:0];
         end
         if (kmh > SPEED_LIMIT) begin
            res.speed = '1;
            res.sat   = 1'b1;
         end else begin
            res.speed = kmh[SPEED_W-1:0];
         end
         return res;
      endfunction

      function void note_request(bit [TICK_W-1:0] now, bit [PULSE_W-1:0] pulses);
         bit [TICK_W-1:0] elapsed;
         if (!primed) begin
            prev_ticks  = now;
            prev_pulses = pulses;
            primed      = 1'b1;
            return;
         end
         elapsed = now - prev_ticks;
         if (elapsed >= sample_ticks) begin
            pulse_sum   = pulse_sum + (pulses - prev_pulses);
            tick_sum    = tick_sum + elapsed;
            prev_pulses = pulses;
            prev_ticks  = now;
         end
         if (tick_sum >= window_ticks) begin
            owed_speeds.push_back(window_speed());
            pulse_sum = '0;
            tick_sum  = '0;
         end
      endfunction

      function void report(string field, longint unsigned want, longint unsigned got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_response(logic [RPM_W-1:0] rpm, logic [SPEED_W-1:0] kmh,
                                   logic sat);
         speed_result_type want;
         if (owed_speeds.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual rpm %0d speed %0d",
                     $time, rpm, kmh);
            return;
         end
         want = owed_speeds.pop_front();
         if (rpm !== want.rpm) begin
            report("rpm_value", want.rpm, rpm);
         end
         if (kmh !== want.speed) begin
            report("kmh_value", want.speed, kmh);
         end
         if (sat !== want.sat) begin
            report("saturated", want.sat, sat);
         end
      endfunction

      function int pending();
         return owed_speeds.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [TICK_W-1:0]     req_now_ticks;
   logic [PULSE_W-1:0]    req_pulse_total;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [RPM_W-1:0]      rsp_rpm_value;
   logic [SPEED_W-1:0]    rsp_kmh_value;
   logic                  rsp_saturated;
   logic                  csr_wr_en;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   speed_scoreboard       sb;
   bit [TICK_W-1:0]       cur_now;
   bit [PULSE_W-1:0]      cur_pulses;
   int unsigned           tick_span;
   int unsigned           pulse_span;
   bit                    idle_on;
   int                    stall_left = 0;
   int                    quiet_cycles = 0;

   pulse_window_speed_meter u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_now_ticks   (req_now_ticks),
      .req_pulse_total (req_pulse_total),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rpm_value   (rsp_rpm_value),
      .rsp_kmh_value   (rsp_kmh_value),
      .rsp_saturated   (rsp_saturated),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: stall in random bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 11);
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check every response taken at this edge against the oldest owed result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_rpm_value, rsp_kmh_value, rsp_saturated);
      end
   end

   // Watchdog: end the run if no handshake completes for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("pulse_window_speed_meter_tb: errors");
         $finish;
      end
   end

   // Present one request, optionally after an idle burst, and hold it until
   // the block takes it. Leave valid high so back-to-back requests need no
   // second assignment in the same step.
   task automatic send_req(bit [TICK_W-1:0] now, bit [PULSE_W-1:0] pulses);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_now_ticks   <= now;
      req_pulse_total <= pulses;
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_request(now, pulses);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Write all five registers back to back; drop the enable once at the end.
   // Scale the random tick step to the window so results keep coming.
   task automatic set_config(logic [CSR_DATA_W-1:0] sample, logic [CSR_DATA_W-1:0] window,
                             logic [CSR_DATA_W-1:0] holes, logic [CSR_DATA_W-1:0] tpm,
                             logic [CSR_DATA_W-1:0] factor);
      write_csr(CSR_SAMPLE_TICKS, sample);
      write_csr(CSR_WINDOW_TICKS, window);
      write_csr(CSR_HOLES_PER_REV, holes);
      write_csr(CSR_TICKS_PER_MINUTE, tpm);
      write_csr(CSR_SPEED_FACTOR, factor);
      csr_wr_en <= 1'b0;
      tick_span = window / 4 + 2 * sample[SAMPLE_W-1:0] + 1;
   endtask

   // Drop valid, wait until every owed result is in, then let the block settle.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly steady streams with random step sizes; some backward steps
   // (huge elapsed count) and some fully random jumps as noise.
   task automatic run_phase(int count);
      int kind;
      case ($urandom_range(0, 3))
         0: pulse_span = 4;
         1: pulse_span = 64;
         2: pulse_span = 4096;
         default: pulse_span = 1 << 20;
      endcase
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 86) begin
            cur_now    = cur_now + $urandom_range(0, tick_span);
            cur_pulses = cur_pulses + $urandom_range(0, pulse_span);
         end else if (kind < 93) begin
            cur_now = cur_now - $urandom_range(1, 3);
         end else begin
            cur_now    = $urandom;
            cur_pulses = $urandom;
         end
         send_req(cur_now, cur_pulses);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] sample;
      logic [CSR_DATA_W-1:0] window;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_now_ticks   = '0;
      req_pulse_total = '0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_SAMPLE_TICKS;
      csr_wdata       = '0;
      idle_on         = 1'b1;
      tick_span       = 11;
      pulse_span      = 64;
      sb              = new();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at the reset settings (sample 2, window 20).
      send_req(32'hFFFF_FFF0, 32'hFFFF_FFFE);   // prime only
      send_req(32'hFFFF_FFF1, 32'h0000_0003);   // below sample_ticks, skip
      send_req(32'h0000_0005, 32'h0000_0010);   // tick and pulse wrap, window closes
      send_req(32'h0000_0005, 32'h0000_0010);   // no time passed
      send_req(32'h0000_0007, 32'h0000_0010);   // sample with zero pulses
      send_req(32'h0000_0006, 32'h8000_0000);   // tick accumulator wraps to a small sum
      send_req(32'h0000_0008, 32'h1000_0000);   // pulse accumulator wraps
      send_req(32'h0000_001C, 32'h1000_0000);   // window closes, rpm clips
      send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // all-ones fields
      send_req(32'h0000_0000, 32'h0000_0000);   // all-zero fields
      send_req(32'h0000_0001, 32'h0000_0000);
      send_req(32'h0000_0015, 32'h0000_0064);   // ordinary window
      send_req(32'h5555_5555, 32'hAAAA_AAAA);
      send_req(32'hAAAA_AAAA, 32'h5555_5555);
      settle();

      // Zero sample and window: every request samples and closes a window;
      // zero holes or a zero tick sum gives an all-zero result.
      set_config(16'd0, 16'd0, 16'd0, 16'd6000, 16'd823);
      send_req(32'hAAAA_AAAA, 32'h5555_5555);
      send_req(32'hAAAA_AAAF, 32'h5555_555C);
      settle();
      set_config(16'd0, 16'd0, 16'd1, 16'd6000, 16'd823);
      send_req(32'hAAAA_AAAF, 32'h5555_5560);
      send_req(32'hAAAA_AAB2, 32'h5555_5569);
      settle();
      cur_now    = 32'hAAAA_AAB2;
      cur_pulses = 32'h5555_5569;

      // Register extremes, low then high.
      set_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
      run_phase(60);
      settle();
      set_config(16'd255, 16'd65535, 16'd255, 16'd65535, 16'd65535);
      run_phase(60);
      settle();

      // Random settings; junk in the upper byte of 8-bit registers must be
      // dropped. Keep the last phase free of idling.
      for (int p = 0; p < 8; p++) begin
         sample = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 4))
                                               : 16'($urandom_range(1, 255));
         case ($urandom_range(0, 4))
            0, 1:    window = 16'($urandom_range(1, 64));
            2, 3:    window = 16'($urandom_range(65, 4000));
            default: window = 16'($urandom_range(4001, 65535));
         endcase
         set_config(sample | (16'($urandom_range(0, 255)) << 8), window,
                    16'($urandom_range(1, 255)) | (16'($urandom_range(0, 255)) << 8),
                    16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
         idle_on = (p != 7) && ($urandom_range(0, 4) != 0);
         run_phase(PHASE_ITEMS);
         settle();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("pulse_window_speed_meter_tb: clean");
      end else begin
         $display("pulse_window_speed_meter_tb: errors");
      end
      $finish;
   end

endmodule
